@@ rtl/tts_pkg.sv @@
package tts_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_RES = 16;
  localparam int TIME_W = 48;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD_ONE = 2'd1;
  localparam logic [1:0] MODE_ADD_PER = 2'd2;
  localparam logic [1:0] MODE_CANCEL = 2'd3;

  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_CANCELLED = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  owner_id;
    logic [15:0] timer_id;
    logic [31:0] delay_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] result_id;
    logic [7:0]  result_owner;
    logic        last;
  } out_word_t;

endpackage

@@ rtl/tts_if.sv @@
interface tts_in_if;
  logic valid;
  logic ready;
  tts_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tts_out_if;
  logic valid;
  logic ready;
  tts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tts_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/timer_table_scheduler_core.sv @@
// Timer table scheduler.
// in: one word per command (tick, add one-shot, add periodic, cancel).
// out: result words; the final word of a command carries last.
// cfg: one-bit enable, to be written only while the block is idle; the block leaves this rule to the user.
// A command is taken only in the idle state. It walks the slot table one slot
// per cycle; a single shared adder forms the due times for adds and reloads:
//   add/cancel: one scan of the table, the act state, then the output handoff.
//   tick: a scan, then for each fired timer a rescan that tells whether
//   another one is due before its word goes out; at most MAX_RES timers
//   fire per tick, each with its output handoff; a quiet tick ends after
//   its scan with no result word.
// Each result sits in one output register; while the receiver stalls the
// sequencer waits, nothing is dropped. Reset clears time, stamps, enable
// and all slot valid bits at once, sets the id counter to 1; no clearing pass.
module timer_table_scheduler_core #(
  parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
  input logic clk,
  input logic rst,
  tts_in_if.sink in,
  tts_out_if.source out,
  tts_cfg_if.sink cfg
);
  import tts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_OUT} state_t;

  state_t state;
  logic enable;
  logic [TIME_W-1:0] now_time;
  logic [15:0] next_id;
  logic [31:0] insert_stamp;
  logic [SLOTS-1:0] slot_valid;
  logic [15:0] slot_ident [SLOTS];
  logic [7:0] slot_owner [SLOTS];
  logic [TIME_W-1:0] slot_due [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic slot_repeat [SLOTS];
  logic [31:0] slot_order [SLOTS];

  in_word_t cmd;
  logic [CW-1:0] idx;
  logic [IW-1:0] cur;
  logic found;
  logic [IW-1:0] best;
  logic [TIME_W-1:0] best_due;
  logic [31:0] best_age;
  logic [4:0] nfired;
  out_word_t res;
  logic res_done;
  logic held;

  logic [31:0] age;
  logic due_ok;
  logic better;
  logic [TIME_W-1:0] add_base;
  logic [31:0] add_off;
  logic [TIME_W-1:0] add_sum;

  assign cur = idx[IW-1:0];
  assign age = insert_stamp - slot_order[cur];
  assign due_ok = slot_valid[cur] && (slot_due[cur] <= now_time);
  assign better = !found || (slot_due[cur] < best_due) ||
                  ((slot_due[cur] == best_due) && (age > best_age));
  assign add_base = now_time;
  assign add_off = (cmd.mode == MODE_TICK) ? slot_period[best] : cmd.delay_ms;
  assign add_sum = add_base + {{(TIME_W-32){1'b0}}, add_off};

  assign in.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out.valid = (state == S_OUT);
  assign out.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enable <= 1'b0;
      now_time <= '0;
      next_id <= 16'd1;
      insert_stamp <= '0;
      slot_valid <= '0;
      found <= 1'b0;
      idx <= '0;
      nfired <= '0;
      res_done <= 1'b0;
      held <= 1'b0;
    end else begin
      if (cfg.valid) enable <= cfg.data;
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            cmd <= in.data;
            idx <= '0;
            found <= 1'b0;
            nfired <= '0;
            held <= 1'b0;
            if (in.data.mode == MODE_TICK) now_time <= now_time + 1'b1;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == CW'(SLOTS)) begin
            state <= S_ACT;
          end else begin
            case (cmd.mode)
              MODE_TICK: begin
                if (enable && due_ok && better) begin
                  found <= 1'b1;
                  best <= cur;
                  best_due <= slot_due[cur];
                  best_age <= age;
                end
              end
              MODE_CANCEL: begin
                if (!found && slot_valid[cur] && slot_ident[cur] == cmd.timer_id &&
                    slot_owner[cur] == cmd.owner_id) begin
                  found <= 1'b1;
                  best <= cur;
                end
              end
              default: begin
                if (!found && !slot_valid[cur]) begin
                  found <= 1'b1;
                  best <= cur;
                end
              end
            endcase
            idx <= idx + 1'b1;
          end
        end
        S_ACT: begin
          case (cmd.mode)
            MODE_TICK: begin
              if (held) begin
                // rescan done: the held word is last when nothing else is due
                held <= 1'b0;
                res.last <= !found;
                res_done <= !found;
                state <= S_OUT;
              end else if (!found) begin
                state <= S_IDLE;
              end else begin
                res.kind <= KIND_FIRED;
                res.result_id <= slot_ident[best];
                res.result_owner <= slot_owner[best];
                nfired <= nfired + 1'b1;
                if (slot_repeat[best]) begin
                  slot_due[best] <= add_sum;
                  slot_order[best] <= insert_stamp;
                  insert_stamp <= insert_stamp + 1'b1;
                end else begin
                  slot_valid[best] <= 1'b0;
                end
                if (nfired == 5'(MAX_RES - 1)) begin
                  res.last <= 1'b1;
                  res_done <= 1'b1;
                  state <= S_OUT;
                end else begin
                  held <= 1'b1;
                  idx <= '0;
                  found <= 1'b0;
                  state <= S_SCAN;
                end
              end
            end
            MODE_CANCEL: begin
              res.result_owner <= cmd.owner_id;
              res.last <= 1'b1;
              res_done <= 1'b1;
              state <= S_OUT;
              if (found && cmd.timer_id != '0) begin
                slot_valid[best] <= 1'b0;
                res.kind <= KIND_CANCELLED;
                res.result_id <= cmd.timer_id;
              end else begin
                res.kind <= KIND_REJECT;
                res.result_id <= '0;
              end
            end
            default: begin
              res.result_owner <= cmd.owner_id;
              res.last <= 1'b1;
              res_done <= 1'b1;
              state <= S_OUT;
              if (found && !(cmd.mode == MODE_ADD_PER && cmd.delay_ms == '0)) begin
                slot_valid[best] <= 1'b1;
                slot_ident[best] <= next_id;
                slot_owner[best] <= cmd.owner_id;
                slot_due[best] <= add_sum;
                slot_period[best] <= cmd.delay_ms;
                slot_repeat[best] <= (cmd.mode == MODE_ADD_PER);
                slot_order[best] <= insert_stamp;
                insert_stamp <= insert_stamp + 1'b1;
                next_id <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 1'b1;
                res.kind <= KIND_ADDED;
                res.result_id <= next_id;
              end else begin
                res.kind <= KIND_REJECT;
                res.result_id <= '0;
              end
            end
          endcase
        end
        S_OUT: begin
          if (out.ready) begin
            if (res_done) begin
              state <= S_IDLE;
            end else begin
              // next due timer is already selected by the rescan
              state <= S_ACT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
